// ----- sv/rss_pkg.sv -----
// Shared types and constants for the record stack sorter.
package rss_pkg;

    localparam int RSS_DEPTH   = 32;
    localparam int RSS_FIELD_W = 16;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_COUNT  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    typedef struct packed {
        logic [2:0]             opcode;
        logic [RSS_FIELD_W-1:0] key_max;
        logic [RSS_FIELD_W-1:0] value_now;
        logic [RSS_FIELD_W-1:0] name_tag;
        logic [RSS_FIELD_W-1:0] limit;
    } rss_in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [RSS_FIELD_W-1:0] out_key;
        logic [RSS_FIELD_W-1:0] out_value;
        logic [RSS_FIELD_W-1:0] out_tag;
        logic [5:0]             match_count;
        logic [5:0]             occupancy;
    } rss_out_t;

    typedef struct packed {
        logic [RSS_FIELD_W-1:0] key;
        logic [RSS_FIELD_W-1:0] value;
        logic [RSS_FIELD_W-1:0] tag;
    } rss_rec_t;

endpackage

// ----- sv/rss_mem.sv -----
// Record memory with one write port and one registered read port.
module rss_mem
    import rss_pkg::*;
#(
    parameter int DEPTH = RSS_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rss_rec_t      wr_data,
    input  logic [AW-1:0] rd_addr,
    output rss_rec_t      rd_data
);

    rss_rec_t mem [DEPTH];
    rss_rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/rss_cmp.sv -----
// Shared magnitude comparator used for key ordering and value limits.
module rss_cmp
    import rss_pkg::*;
(
    input  logic [RSS_FIELD_W-1:0] cmp_a,
    input  logic [RSS_FIELD_W-1:0] cmp_b,
    output logic                   a_gt_b
);

    assign a_gt_b = (cmp_a > cmp_b);

endmodule

// ----- sv/record_stack_sorter.sv -----
// Record stack sorter top level: sequencer around a record memory and a shared comparator.
// Count does one memory read per compare over the n stored records.
// Sort first reverses the stored records, then runs bubble passes.
// One item is worked at a time; the next is accepted once the result is registered.
// Reset is synchronous and active low; it empties the stack and drops any pending result.
module record_stack_sorter
    import rss_pkg::*;
#(
    parameter int DEPTH = RSS_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rss_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rss_out_t m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POP,
        S_RV_A, S_RV_B, S_RV_W1, S_RV_W2,
        S_BS_START, S_BS_LOAD, S_BS_CMP, S_BS_END,
        S_CNT_RD, S_CNT_CMP, S_OUT
    } state_t;

    state_t        state_reg;
    rss_in_t       in_reg;
    logic [AW-1:0] bottom_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] p_reg;
    logic [AW-1:0] last_reg;
    logic          swapped_reg;
    rss_rec_t      carry_reg;
    rss_rec_t      hold_reg;
    rss_rec_t      res_rec_reg;
    logic [1:0]    res_status_reg;
    logic [CW-1:0] match_reg;
    logic          m_valid_reg;
    rss_out_t      m_data_reg;

    logic [CW-1:0] count_m1;
    logic [AW-1:0] top_pos;
    logic [AW-1:0] j_pos;
    logic [AW-1:0] bottom_dec;
    logic          insert_zero;
    logic          insert_full;
    logic          rv_more;

    logic          wr_en;
    logic          wr_bottom;
    logic [AW-1:0] wr_pos;
    logic [AW-1:0] wr_addr;
    rss_rec_t      wr_data;
    logic [AW-1:0] rd_pos;
    logic [AW-1:0] rd_addr;
    rss_rec_t      rd_data;

    logic [RSS_FIELD_W-1:0] cmp_a;
    logic [RSS_FIELD_W-1:0] cmp_b;
    logic                   a_gt_b;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign count_m1    = count_reg - CW'(1);
    assign top_pos     = count_m1[AW-1:0];
    assign j_pos       = top_pos - p_reg;
    assign bottom_dec  = (bottom_reg == '0) ? AW'(DEPTH - 1) : bottom_reg - AW'(1);
    assign insert_zero = (in_reg.key_max == '0) || (in_reg.value_now == '0);
    assign insert_full = (count_reg >= DEPTH_C);
    assign rv_more     = ((CW'(p_reg) + CW'(1)) < (count_reg >> 1));

    always_comb begin
        rd_pos    = '0;
        wr_en     = 1'b0;
        wr_bottom = 1'b0;
        wr_pos    = '0;
        wr_data   = rd_data;
        cmp_a     = carry_reg.key;
        cmp_b     = rd_data.key;
        case (state_reg)
            S_DECODE: begin
                case (in_reg.opcode)
                    OP_PUSH, OP_APPEND: begin
                        wr_en     = !insert_zero && !insert_full;
                        wr_bottom = (in_reg.opcode == OP_APPEND);
                        wr_pos    = count_reg[AW-1:0];
                        wr_data   = '{key: in_reg.key_max, value: in_reg.value_now,
                                      tag: in_reg.name_tag};
                    end
                    OP_POP: begin
                        rd_pos = top_pos;
                    end
                    default: begin
                    end
                endcase
            end
            S_RV_A: begin
                rd_pos = p_reg;
            end
            S_RV_B: begin
                rd_pos = j_pos;
            end
            S_RV_W1: begin
                wr_en  = 1'b1;
                wr_pos = p_reg;
            end
            S_RV_W2: begin
                wr_en   = 1'b1;
                wr_pos  = j_pos;
                wr_data = hold_reg;
            end
            S_BS_LOAD: begin
                rd_pos = p_reg;
            end
            S_BS_CMP: begin
                wr_en   = 1'b1;
                wr_pos  = p_reg - AW'(1);
                wr_data = a_gt_b ? rd_data : carry_reg;
                rd_pos  = p_reg + AW'(1);
            end
            S_BS_END: begin
                wr_en   = 1'b1;
                wr_pos  = last_reg;
                wr_data = carry_reg;
            end
            S_CNT_RD: begin
                rd_pos = p_reg;
            end
            S_CNT_CMP: begin
                cmp_a = rd_data.value;
                cmp_b = in_reg.limit;
            end
            default: begin
            end
        endcase
        wr_addr = wr_bottom ? bottom_dec : slot_of(bottom_reg, wr_pos);
        rd_addr = slot_of(bottom_reg, rd_pos);
    end

    rss_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rss_cmp u_cmp (
        .cmp_a  (cmp_a),
        .cmp_b  (cmp_b),
        .a_gt_b (a_gt_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            bottom_reg  <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    res_status_reg <= ST_OK;
                    res_rec_reg    <= '0;
                    match_reg      <= '0;
                    state_reg      <= S_OUT;
                    case (in_reg.opcode)
                        OP_PUSH, OP_APPEND: begin
                            if (insert_zero) begin
                                res_status_reg <= ST_REJECT;
                            end else if (insert_full) begin
                                res_status_reg <= ST_FULL;
                            end else begin
                                count_reg <= count_reg + CW'(1);
                                if (in_reg.opcode == OP_APPEND) begin
                                    bottom_reg <= bottom_dec;
                                end
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                res_status_reg <= ST_EMPTY;
                            end else begin
                                state_reg <= S_POP;
                            end
                        end
                        OP_SORT: begin
                            p_reg       <= '0;
                            swapped_reg <= 1'b0;
                            last_reg    <= top_pos;
                            if (count_reg >= CW'(2)) begin
                                state_reg <= S_RV_A;
                            end
                        end
                        OP_COUNT: begin
                            p_reg <= '0;
                            if (count_reg != '0) begin
                                state_reg <= S_CNT_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_POP: begin
                    res_rec_reg <= rd_data;
                    count_reg   <= count_m1;
                    state_reg   <= S_OUT;
                end
                S_RV_A: begin
                    state_reg <= S_RV_B;
                end
                S_RV_B: begin
                    hold_reg  <= rd_data;
                    state_reg <= S_RV_W1;
                end
                S_RV_W1: begin
                    state_reg <= S_RV_W2;
                end
                S_RV_W2: begin
                    if (rv_more) begin
                        p_reg     <= p_reg + AW'(1);
                        state_reg <= S_RV_A;
                    end else begin
                        state_reg <= S_BS_START;
                    end
                end
                S_BS_START: begin
                    p_reg     <= AW'(1);
                    state_reg <= S_BS_LOAD;
                end
                S_BS_LOAD: begin
                    carry_reg <= rd_data;
                    state_reg <= S_BS_CMP;
                end
                S_BS_CMP: begin
                    if (a_gt_b) begin
                        swapped_reg <= 1'b1;
                    end else begin
                        carry_reg <= rd_data;
                    end
                    if (p_reg == last_reg) begin
                        state_reg <= S_BS_END;
                    end else begin
                        p_reg <= p_reg + AW'(1);
                    end
                end
                S_BS_END: begin
                    if (!swapped_reg || (last_reg == AW'(1))) begin
                        state_reg <= S_OUT;
                    end else begin
                        last_reg    <= last_reg - AW'(1);
                        swapped_reg <= 1'b0;
                        state_reg   <= S_BS_START;
                    end
                end
                S_CNT_RD: begin
                    state_reg <= S_CNT_CMP;
                end
                S_CNT_CMP: begin
                    if (!a_gt_b) begin
                        match_reg <= match_reg + CW'(1);
                    end
                    if (p_reg == top_pos) begin
                        state_reg <= S_OUT;
                    end else begin
                        p_reg     <= p_reg + AW'(1);
                        state_reg <= S_CNT_RD;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.status      <= res_status_reg;
                        m_data_reg.out_key     <= res_rec_reg.key;
                        m_data_reg.out_value   <= res_rec_reg.value;
                        m_data_reg.out_tag     <= res_rec_reg.tag;
                        m_data_reg.match_count <= 6'(match_reg);
                        m_data_reg.occupancy   <= 6'(count_reg);
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
